### hdl/vat_pkg.sv
`timescale 1ns / 1ps
// vat_pkg: shared constants, codes, width helpers, quaternion arithmetic helpers
// and the stage-enable struct for the vector affine transform. No dependencies.

package vat_pkg;

	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_COEF_WIDTH  = 16;

	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int OFFSET_W  = 32;
	localparam int QUAT_W    = 16;
	localparam int QUAT_FRAC = 14;

	// doubled quaternion products and 1.0 - a - b sums
	localparam int QRAW_W = 2 * QUAT_W + 2;
	// quaternion coefficient after truncation to Q.14
	localparam int QC_W   = QRAW_W - QUAT_FRAC;

	localparam logic [MODE_W-1:0] MODE_POINT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUAT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_XY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT      = 3'd6;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} vat_ctl_t;

	function automatic int coef_mul_w(input int kw);
		return (kw > QC_W) ? kw : QC_W;
	endfunction

	function automatic int acc_w(input int cw, input int kw);
		int pw;
		int tw;
		pw = cw + coef_mul_w(kw);
		tw = OFFSET_W + kw - 4;
		return ((pw > tw) ? pw : tw) + 2;
	endfunction

	function automatic int cfg_dw(input int kw);
		return (3 * kw > 4 * QUAT_W) ? 3 * kw : 4 * QUAT_W;
	endfunction

	function automatic logic signed [QRAW_W-1:0] dbl_ext(
		input logic signed [2*QUAT_W-1:0] p
	);
		return {{(QRAW_W - 2 * QUAT_W - 1){p[2*QUAT_W-1]}}, p, 1'b0};
	endfunction

	function automatic logic signed [QC_W-1:0] quat_trunc(
		input logic signed [QRAW_W-1:0] raw
	);
		logic signed [QRAW_W-1:0] bias;
		logic signed [QRAW_W-1:0] sum;
		bias = raw[QRAW_W-1] ? QRAW_W'((1 << QUAT_FRAC) - 1) : QRAW_W'(0);
		sum  = raw + bias;
		return sum[QRAW_W-1:QUAT_FRAC];
	endfunction

endpackage

### hdl/vat_coef.sv
`timescale 1ns / 1ps
// vat_coef: stages 1 and 2. Captures the vector, forms quaternion products and
// selects the 3x3 coefficients. Depends on vat_pkg.

module vat_coef #(
	parameter int COORD_WIDTH = vat_pkg::DEF_COORD_WIDTH,
	parameter int COEF_WIDTH  = vat_pkg::DEF_COEF_WIDTH
) (
	input  logic                                              clk,
	input  vat_pkg::vat_ctl_t                                 ctl,
	input  logic [vat_pkg::MODE_W-1:0]                        mode,
	input  logic [3*COEF_WIDTH-1:0]                           row_x,
	input  logic [3*COEF_WIDTH-1:0]                           row_y,
	input  logic [3*COEF_WIDTH-1:0]                           row_z,
	input  logic [4*vat_pkg::QUAT_W-1:0]                      quat,
	input  logic signed [COORD_WIDTH-1:0]                     in_x,
	input  logic signed [COORD_WIDTH-1:0]                     in_y,
	input  logic signed [COORD_WIDTH-1:0]                     in_z,
	input  logic                                              in_last,
	output logic signed [COORD_WIDTH-1:0]                     vec_s2 [3],
	output logic                                              last_s2,
	output logic signed [vat_pkg::coef_mul_w(COEF_WIDTH)-1:0] coef_s2 [9]
);
	import vat_pkg::*;

	localparam int CMW = coef_mul_w(COEF_WIDTH);
	localparam logic signed [QRAW_W-1:0] Q_ONE = QRAW_W'(1) << (2 * QUAT_FRAC);

	logic signed [COORD_WIDTH-1:0] vec_s1 [3];
	logic                          last_s1;
	logic signed [QUAT_W-1:0]      qx, qy, qz, qw;
	logic signed [2*QUAT_W-1:0]    xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [2*QUAT_W-1:0]    wx_s1, wy_s1, wz_s1;
	logic signed [QRAW_W-1:0]      raw [9];
	logic signed [CMW-1:0]         coef_nx [9];
	logic [3*COEF_WIDTH-1:0]       rows [3];

	assign qx = quat[4*QUAT_W-1 -: QUAT_W];
	assign qy = quat[3*QUAT_W-1 -: QUAT_W];
	assign qz = quat[2*QUAT_W-1 -: QUAT_W];
	assign qw = quat[QUAT_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			vec_s1[0] <= in_x;
			vec_s1[1] <= in_y;
			vec_s1[2] <= in_z;
			last_s1   <= in_last;
			xx_s1     <= qx * qx;
			yy_s1     <= qy * qy;
			zz_s1     <= qz * qz;
			xy_s1     <= qx * qy;
			xz_s1     <= qx * qz;
			yz_s1     <= qy * qz;
			wx_s1     <= qx * qw;
			wy_s1     <= qy * qw;
			wz_s1     <= qz * qw;
		end
	end

	always_comb begin
		rows[0] = row_x;
		rows[1] = row_y;
		rows[2] = row_z;
		raw[0] = Q_ONE - dbl_ext(yy_s1) - dbl_ext(zz_s1);
		raw[1] = dbl_ext(xy_s1) - dbl_ext(wz_s1);
		raw[2] = dbl_ext(xz_s1) + dbl_ext(wy_s1);
		raw[3] = dbl_ext(xy_s1) + dbl_ext(wz_s1);
		raw[4] = Q_ONE - dbl_ext(xx_s1) - dbl_ext(zz_s1);
		raw[5] = dbl_ext(yz_s1) - dbl_ext(wx_s1);
		raw[6] = dbl_ext(xz_s1) - dbl_ext(wy_s1);
		raw[7] = dbl_ext(yz_s1) + dbl_ext(wx_s1);
		raw[8] = Q_ONE - dbl_ext(xx_s1) - dbl_ext(yy_s1);
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (mode == MODE_QUAT) begin
					coef_nx[r*3+k] = CMW'(quat_trunc(raw[r*3+k]));
				end else begin
					coef_nx[r*3+k] =
						CMW'(signed'(rows[r][(2-k)*COEF_WIDTH +: COEF_WIDTH]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			vec_s2  <= vec_s1;
			last_s2 <= last_s1;
			coef_s2 <= coef_nx;
		end
	end

endmodule

### hdl/vat_mac.sv
`timescale 1ns / 1ps
// vat_mac: stages 3 and 4. Nine coordinate-by-coefficient products, then the
// row sums with translation (point mode only) and truncation toward zero. Depends on vat_pkg.

module vat_mac #(
	parameter int COORD_WIDTH = vat_pkg::DEF_COORD_WIDTH,
	parameter int COEF_WIDTH  = vat_pkg::DEF_COEF_WIDTH
) (
	input  logic                                                    clk,
	input  vat_pkg::vat_ctl_t                                       ctl,
	input  logic [vat_pkg::MODE_W-1:0]                              mode,
	input  logic [2*vat_pkg::OFFSET_W-1:0]                          offset_xy,
	input  logic signed [vat_pkg::OFFSET_W-1:0]                     offset_z,
	input  logic signed [COORD_WIDTH-1:0]                           vec_s2 [3],
	input  logic                                                    last_s2,
	input  logic signed [vat_pkg::coef_mul_w(COEF_WIDTH)-1:0]       coef_s2 [9],
	output logic signed [vat_pkg::acc_w(COORD_WIDTH, COEF_WIDTH)-1:0] res_s4 [3],
	output logic                                                    last_s4
);
	import vat_pkg::*;

	localparam int CMW  = coef_mul_w(COEF_WIDTH);
	localparam int PW   = COORD_WIDTH + CMW;
	localparam int ACCW = acc_w(COORD_WIDTH, COEF_WIDTH);
	localparam int KF   = COEF_WIDTH - 4;

	logic signed [PW-1:0]       prod_s3 [9];
	logic                       last_s3;
	logic signed [OFFSET_W-1:0] offs [3];
	logic signed [ACCW-1:0]     acc [3];
	logic signed [ACCW-1:0]     sum_q [3];
	logic signed [ACCW-1:0]     sum_m [3];
	logic signed [ACCW-1:0]     res_nx [3];

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s3[r*3+k] <= vec_s2[k] * coef_s2[r*3+k];
				end
			end
			last_s3 <= last_s2;
		end
	end

	always_comb begin
		offs[0] = signed'(offset_xy[2*OFFSET_W-1 -: OFFSET_W]);
		offs[1] = signed'(offset_xy[OFFSET_W-1:0]);
		offs[2] = offset_z;
		for (int r = 0; r < 3; r++) begin
			if (mode == MODE_POINT) begin
				acc[r] = ACCW'(offs[r]) <<< KF;
			end else begin
				acc[r] = '0;
			end
			acc[r] = acc[r] + ACCW'(prod_s3[r*3]) + ACCW'(prod_s3[r*3+1])
				+ ACCW'(prod_s3[r*3+2]);
			// bias negatives so the arithmetic shift truncates toward zero
			if (acc[r][ACCW-1]) begin
				sum_q[r] = acc[r] + ACCW'((1 << QUAT_FRAC) - 1);
				sum_m[r] = acc[r] + ACCW'((1 << KF) - 1);
			end else begin
				sum_q[r] = acc[r];
				sum_m[r] = acc[r];
			end
			if (mode == MODE_QUAT) begin
				res_nx[r] = sum_q[r] >>> QUAT_FRAC;
			end else begin
				res_nx[r] = sum_m[r] >>> KF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			res_s4  <= res_nx;
			last_s4 <= last_s3;
		end
	end

endmodule

### hdl/vat_sat.sv
`timescale 1ns / 1ps
// vat_sat: stage 5, the output register. Clamps each component to the
// coordinate range and flags any clamp. Depends on vat_pkg.

module vat_sat #(
	parameter int COORD_WIDTH = vat_pkg::DEF_COORD_WIDTH,
	parameter int COEF_WIDTH  = vat_pkg::DEF_COEF_WIDTH
) (
	input  logic                                                    clk,
	input  vat_pkg::vat_ctl_t                                       ctl,
	input  logic signed [vat_pkg::acc_w(COORD_WIDTH, COEF_WIDTH)-1:0] res_s4 [3],
	input  logic                                                    last_s4,
	output logic signed [COORD_WIDTH-1:0]                           x_s5,
	output logic signed [COORD_WIDTH-1:0]                           y_s5,
	output logic signed [COORD_WIDTH-1:0]                           z_s5,
	output logic                                                    last_s5,
	output logic                                                    sat_s5
);
	import vat_pkg::*;

	localparam int ACCW = acc_w(COORD_WIDTH, COEF_WIDTH);

	logic [ACCW-COORD_WIDTH:0]     top_bits [3];
	logic [2:0]                    ovf;
	logic signed [COORD_WIDTH-1:0] clamped [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			top_bits[r] = res_s4[r][ACCW-1:COORD_WIDTH-1];
			ovf[r]      = !((&top_bits[r]) || !(|top_bits[r]));
			if (ovf[r]) begin
				clamped[r] = {res_s4[r][ACCW-1], {(COORD_WIDTH-1){~res_s4[r][ACCW-1]}}};
			end else begin
				clamped[r] = res_s4[r][COORD_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			x_s5    <= clamped[0];
			y_s5    <= clamped[1];
			z_s5    <= clamped[2];
			last_s5 <= last_s4;
			sat_s5  <= |ovf;
		end
	end

endmodule

### hdl/vector_affine_transform.sv
`timescale 1ns / 1ps
// vector_affine_transform: top level. Configuration registers, stage valid
// bits and stall chain. Depends on vat_pkg, vat_coef, vat_mac, vat_sat.

// Takes one Q16.16 vector per clock while in_stall is low and returns the
// results in order, one result per input. The five stages are: quaternion
// products, coefficient selection, the nine products, row sums with
// truncation, and saturation into the output register. Each stage holds
// only while the one after it is full and held, so bubbles are squeezed out
// under out_stall. Write configuration only while the pipeline is empty; it
// is read directly by the stages in flight.

module vector_affine_transform #(
	parameter int COORD_WIDTH = vat_pkg::DEF_COORD_WIDTH,
	parameter int COEF_WIDTH  = vat_pkg::DEF_COEF_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [vat_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vat_pkg::cfg_dw(COEF_WIDTH)-1:0] cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [COORD_WIDTH-1:0]          in_x,
	input  logic signed [COORD_WIDTH-1:0]          in_y,
	input  logic signed [COORD_WIDTH-1:0]          in_z,
	input  logic                                   in_last,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [COORD_WIDTH-1:0]          out_x,
	output logic signed [COORD_WIDTH-1:0]          out_y,
	output logic signed [COORD_WIDTH-1:0]          out_z,
	output logic                                   out_last,
	output logic                                   saturated
);
	import vat_pkg::*;

	localparam int CMW  = coef_mul_w(COEF_WIDTH);
	localparam int ACCW = acc_w(COORD_WIDTH, COEF_WIDTH);
	localparam int KF   = COEF_WIDTH - 4;
	localparam logic [COEF_WIDTH-1:0] K_ONE = COEF_WIDTH'(1 << KF);

	logic [MODE_W-1:0]          mode_q;
	logic [3*COEF_WIDTH-1:0]    row_x_q, row_y_q, row_z_q;
	logic [2*OFFSET_W-1:0]      offset_xy_q;
	logic signed [OFFSET_W-1:0] offset_z_q;
	logic [4*QUAT_W-1:0]        quat_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	vat_ctl_t ctl;

	logic signed [COORD_WIDTH-1:0] vec_s2 [3];
	logic                          last_s2;
	logic signed [CMW-1:0]         coef_s2 [9];
	logic signed [ACCW-1:0]        res_s4 [3];
	logic                          last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_POINT;
			row_x_q     <= {K_ONE, (2*COEF_WIDTH)'(0)};
			row_y_q     <= {COEF_WIDTH'(0), K_ONE, COEF_WIDTH'(0)};
			row_z_q     <= {(2*COEF_WIDTH)'(0), K_ONE};
			offset_xy_q <= '0;
			offset_z_q  <= '0;
			quat_q      <= (4*QUAT_W)'(1 << QUAT_FRAC);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:      mode_q      <= cfg_wdata[MODE_W-1:0];
				REG_ROW_X:     row_x_q     <= cfg_wdata[3*COEF_WIDTH-1:0];
				REG_ROW_Y:     row_y_q     <= cfg_wdata[3*COEF_WIDTH-1:0];
				REG_ROW_Z:     row_z_q     <= cfg_wdata[3*COEF_WIDTH-1:0];
				REG_OFFSET_XY: offset_xy_q <= cfg_wdata[2*OFFSET_W-1:0];
				REG_OFFSET_Z:  offset_z_q  <= cfg_wdata[OFFSET_W-1:0];
				REG_QUAT:      quat_q      <= cfg_wdata[4*QUAT_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on
	assign rdy5 = !vld_s5 || !out_stall;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign ctl.en_s1 = rdy1;
	assign ctl.en_s2 = rdy2;
	assign ctl.en_s3 = rdy3;
	assign ctl.en_s4 = rdy4;
	assign ctl.en_s5 = rdy5;

	assign in_stall  = !rdy1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	vat_coef #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEF_WIDTH (COEF_WIDTH)
	) u_coef (
		.clk    (clk),
		.ctl    (ctl),
		.mode   (mode_q),
		.row_x  (row_x_q),
		.row_y  (row_y_q),
		.row_z  (row_z_q),
		.quat   (quat_q),
		.in_x   (in_x),
		.in_y   (in_y),
		.in_z   (in_z),
		.in_last(in_last),
		.vec_s2 (vec_s2),
		.last_s2(last_s2),
		.coef_s2(coef_s2)
	);

	vat_mac #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEF_WIDTH (COEF_WIDTH)
	) u_mac (
		.clk      (clk),
		.ctl      (ctl),
		.mode     (mode_q),
		.offset_xy(offset_xy_q),
		.offset_z (offset_z_q),
		.vec_s2   (vec_s2),
		.last_s2  (last_s2),
		.coef_s2  (coef_s2),
		.res_s4   (res_s4),
		.last_s4  (last_s4)
	);

	vat_sat #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEF_WIDTH (COEF_WIDTH)
	) u_sat (
		.clk    (clk),
		.ctl    (ctl),
		.res_s4 (res_s4),
		.last_s4(last_s4),
		.x_s5   (out_x),
		.y_s5   (out_y),
		.z_s5   (out_z),
		.last_s5(out_last),
		.sat_s5 (saturated)
	);

endmodule
